// ===== rtl/core/sum8_frame_validator_defines.svh =====
// assertion macros for the sum8 frame validator rtl
// no dependencies; included by s8fv_frame_check, the module that carries assertions
`ifndef SUM8_FRAME_VALIDATOR_DEFINES_SVH
`define SUM8_FRAME_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define S8FV_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("s8fv assertion failed");

// next-cycle implication, disabled while reset is low
`define S8FV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("s8fv assertion failed");

`endif

// ===== rtl/core/s8fv_pkg.sv =====
// types and constants of the sum8 frame validator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package s8fv_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_datagram;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [7:0] payload_index;
        logic [2:0] status;
        logic [7:0] source_id;
        logic [7:0] group_number;
        logic [7:0] declared_length;
    } result_t;

    localparam logic [7:0] PRE0            = 8'h80;
    localparam logic [7:0] PRE1            = 8'h81;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'hFF;
    localparam logic [9:0] MIN_FRAME       = 10'd6;
    localparam logic [8:0] HDR_LEN         = 9'd5;
    localparam logic [8:0] COUNT_MAX       = 9'd511;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_BAD_PRE    = 3'd2;
    localparam logic [2:0] ST_SHORT_LEN  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;
    localparam logic [2:0] ST_CHECKSUM   = 3'd5;

endpackage

// ===== rtl/core/s8fv_in_stage.sv =====
// input register of the sum8 frame validator
// depends on s8fv_pkg
`timescale 1ns / 1ps

module s8fv_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  s8fv_pkg::in_item_t  s_data,
    input  logic                advance,
    output logic                item_valid,
    output s8fv_pkg::in_item_t  item
);
    import s8fv_pkg::*;

    logic     vld_reg;
    in_item_t data_reg;

    // a held transaction leaving this cycle frees the slot
    assign s_ready    = !vld_reg || advance;
    assign item_valid = vld_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (advance) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== rtl/core/s8fv_frame_check.sv =====
// datagram state and per-byte check logic of the sum8 frame validator
// depends on s8fv_pkg and sum8_frame_validator_defines.svh
`timescale 1ns / 1ps

`include "sum8_frame_validator_defines.svh"

module s8fv_frame_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  s8fv_pkg::in_item_t  item,
    input  logic [7:0]          max_payload,
    output logic                res_valid,
    output s8fv_pkg::result_t   res
);
    import s8fv_pkg::*;

    logic [8:0] byte_count_reg, byte_count_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic       preamble_bad_reg, preamble_bad_next;
    logic [7:0] held_source_reg, held_source_next;
    logic [7:0] held_group_reg, held_group_next;
    logic [7:0] held_length_reg, held_length_next;
    logic       checksum_ok_reg, checksum_ok_next;

    logic       first;
    logic [7:0] b;
    logic [8:0] payload_end;
    logic       emit_payload;
    logic [8:0] pidx_wide;
    logic [9:0] flen;
    logic [9:0] len_need;
    logic [2:0] st;

    assign b = item.rx_byte;

    always_comb begin
        first = (byte_count_reg == 9'd0);

        // first byte of a datagram starts from cleared state
        running_sum_next  = first ? 8'd0 : running_sum_reg;
        preamble_bad_next = first ? 1'b0 : preamble_bad_reg;
        checksum_ok_next  = first ? 1'b0 : checksum_ok_reg;
        held_source_next  = first ? 8'd0 : held_source_reg;
        held_group_next   = first ? 8'd0 : held_group_reg;
        held_length_next  = first ? 8'd0 : held_length_reg;
        byte_count_next   = byte_count_reg;

        payload_end  = HDR_LEN + {1'b0, held_length_next};
        emit_payload = 1'b0;
        pidx_wide    = byte_count_reg - HDR_LEN;

        if (byte_count_reg != COUNT_MAX) begin
            if (byte_count_reg == 9'd0) begin
                preamble_bad_next = (b != PRE0);
            end else if (byte_count_reg == 9'd1) begin
                preamble_bad_next = preamble_bad_next || (b != PRE1);
            end else if (byte_count_reg < HDR_LEN) begin
                if (byte_count_reg == 9'd2) begin
                    held_source_next = b;
                end else if (byte_count_reg == 9'd3) begin
                    held_group_next = b;
                end else begin
                    held_length_next = b;
                end
                running_sum_next = running_sum_next + b;
            end else if (byte_count_reg < payload_end) begin
                running_sum_next = running_sum_next + b;
                emit_payload     = 1'b1;
            end else if (byte_count_reg == payload_end) begin
                checksum_ok_next = (b == running_sum_next);
            end
            byte_count_next = byte_count_reg + 9'd1;
        end

        // verdict, first matching check wins
        flen     = {1'b0, byte_count_reg} + 10'd1;
        len_need = MIN_FRAME + {2'b00, held_length_next};
        if (flen < MIN_FRAME) begin
            st = ST_SHORT;
        end else if (preamble_bad_next) begin
            st = ST_BAD_PRE;
        end else if (flen < len_need) begin
            st = ST_SHORT_LEN;
        end else if (held_length_next > max_payload) begin
            st = ST_TOO_LONG;
        end else if (!checksum_ok_next) begin
            st = ST_CHECKSUM;
        end else begin
            st = ST_OK;
        end

        res = '0;
        if (item.end_of_datagram) begin
            byte_count_next     = 9'd0;
            res.result_kind     = KIND_STATUS;
            res.status          = st;
            res.source_id       = held_source_next;
            res.group_number    = held_group_next;
            res.declared_length = held_length_next;
        end else if (emit_payload) begin
            res.result_kind   = KIND_PAYLOAD;
            res.data_byte     = b;
            res.payload_index = pidx_wide[7:0];
        end
        res_valid = item.end_of_datagram || emit_payload;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= 9'd0;
            running_sum_reg  <= 8'd0;
            preamble_bad_reg <= 1'b0;
            held_source_reg  <= 8'd0;
            held_group_reg   <= 8'd0;
            held_length_reg  <= 8'd0;
            checksum_ok_reg  <= 1'b0;
        end else if (fire) begin
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
            preamble_bad_reg <= preamble_bad_next;
            held_source_reg  <= held_source_next;
            held_group_reg   <= held_group_next;
            held_length_reg  <= held_length_next;
            checksum_ok_reg  <= checksum_ok_next;
        end
    end

    `S8FV_ASSERT_NEXT(a_eod_restarts, aclk, aresetn, fire && item.end_of_datagram, byte_count_reg == 9'd0)
    `S8FV_ASSERT_NEXT(a_count_steps, aclk, aresetn, fire && !item.end_of_datagram && (byte_count_reg != COUNT_MAX), byte_count_reg == $past(byte_count_reg) + 9'd1)
    `S8FV_ASSERT_NOW(a_eod_gives_status, aclk, aresetn, fire && item.end_of_datagram, res_valid && (res.result_kind == KIND_STATUS))
    `S8FV_ASSERT_NOW(a_payload_clean, aclk, aresetn, res_valid && (res.result_kind == KIND_PAYLOAD), (res.status == ST_OK) && (res.declared_length == 8'd0) && (byte_count_reg >= HDR_LEN))

endmodule

// ===== rtl/core/s8fv_out_stage.sv =====
// result register of the sum8 frame validator
// depends on s8fv_pkg
`timescale 1ns / 1ps

module s8fv_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  s8fv_pkg::result_t  res,
    output logic               can_take,
    output logic               m_valid,
    input  logic               m_ready,
    output s8fv_pkg::result_t  m_data
);
    import s8fv_pkg::*;

    logic    vld_reg;
    result_t data_reg;

    // free when empty or when the held transaction leaves this cycle
    assign can_take = !vld_reg || m_ready;
    assign m_valid  = vld_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (load) begin
            vld_reg <= 1'b1;
        end else if (m_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

endmodule

// ===== rtl/core/sum8_frame_validator.sv =====
// Checks received datagrams fed one byte per transaction (preamble 0x80 0x81, source, group,
// length, payload, 8-bit additive checksum). One byte is taken every cycle while results
// drain; each byte passes an input register and the check stage into the result register,
// from which its result is presented. The rate is set by the running sum and byte counter
// in the check stage, which are updated once per byte. Payload bytes come out unverified
// as they arrive; the byte marked end of datagram yields one status transaction instead.
// max_payload resets to 255 and is written through the cfg channel; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// top level of the sum8 frame validator
// depends on s8fv_pkg, s8fv_in_stage, s8fv_frame_check, s8fv_out_stage
`timescale 1ns / 1ps

module sum8_frame_validator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  s8fv_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output s8fv_pkg::result_t   m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import s8fv_pkg::*;

    logic       max_payload_reg;
    logic [7:0] max_payload_q_reg;
    logic       item_valid;
    in_item_t   item;
    logic       can_take;
    logic       advance;
    logic       res_valid;
    result_t    res;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && can_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg   <= 1'b0;
            max_payload_q_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_payload_reg   <= 1'b1;
            max_payload_q_reg <= cfg_data;
        end
    end

    s8fv_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    s8fv_frame_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (advance),
        .item        (item),
        .max_payload (max_payload_reg ? max_payload_q_reg : MAX_PAYLOAD_RST),
        .res_valid   (res_valid),
        .res         (res)
    );

    s8fv_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res      (res),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
